// ===== rtl/tnq_pkg.sv =====
package tnq_pkg;

    localparam int FREQ_W     = 16;
    localparam int LEN_W      = 16;
    localparam int URG_W      = 9;
    localparam int ELAPSED_W  = 17;
    localparam int CMD_W      = 3;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int BEAT_PERIOD_MS_DEF = 1000;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // metronome tone shaping
    localparam logic [URG_W-1:0]  URG_FULL    = 9'd256;
    localparam logic [FREQ_W-1:0] TICK_BASE   = 16'd60;
    localparam logic [FREQ_W-1:0] TOCK_BASE   = 16'd140;
    localparam logic [6:0]        URG_GAIN    = 7'd75;
    localparam logic [LEN_W-1:0]  BEAT_TONE_MS = 16'd50;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_URGENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH    = 2'd2;

    localparam logic [URG_W-1:0]  URG_RST  = 9'd256;
    localparam logic [FREQ_W-1:0] LOW_RST  = 16'd31;
    localparam logic [FREQ_W-1:0] HIGH_RST = 16'd4978;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [FREQ_W-1:0] freq;
    } t_note;

    localparam int NOTE_W = $bits(t_note);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
    } t_item;

    typedef struct packed {
        logic [URG_W-1:0]  urgency;
        logic [FREQ_W-1:0] low;
        logic [FREQ_W-1:0] high;
    } t_cfg;

    typedef struct packed {
        logic              dropped;
        logic [FILL_W-1:0] fill;
        logic              busy;
        logic [FREQ_W-1:0] freq;
        logic              tone_on;
    } t_result;

endpackage

// ===== rtl/tnq_note_mem.sv =====
module tnq_note_mem #(
    parameter int QUEUE_DEPTH = tnq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  tnq_pkg::t_note                 i_wdata,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output tnq_pkg::t_note                 o_rdata
);
    import tnq_pkg::*;

    t_note r_mem [QUEUE_DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-through so the head entry is current when just written
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tnq_core.sv =====
module tnq_core #(
    parameter int QUEUE_DEPTH    = tnq_pkg::QUEUE_DEPTH_DEF,
    parameter int BEAT_PERIOD_MS = tnq_pkg::BEAT_PERIOD_MS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  tnq_pkg::t_item                 i_item,
    input  tnq_pkg::t_cfg                  i_cfg,
    input  tnq_pkg::t_note                 i_head_data,
    output logic                           o_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_wr_addr,
    output tnq_pkg::t_note                 o_wr_data,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_addr,
    output tnq_pkg::t_result               o_res
);
    import tnq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW = $clog2(BEAT_PERIOD_MS + 2);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_W  = (CW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_TOP = AW'(QUEUE_DEPTH - 1);
    localparam logic [BW-1:0] PERIOD   = BW'(BEAT_PERIOD_MS);

    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [FREQ_W-1:0]    r_cur_freq, n_cur_freq;
    logic [LEN_W-1:0]     r_cur_len, n_cur_len;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_active, n_active;
    logic                 r_sounding, n_sounding;
    logic                 r_metro, n_metro;
    logic                 r_tock, n_tock;
    logic [BW-1:0]        r_beat, n_beat;

    logic [URG_W-1:0]     urg_clamp;
    logic [15:0]          urg_prod;
    logic [FREQ_W-1:0]    beat_step;
    logic                 full;
    logic [CW:0]          tail_sum;
    logic [AW-1:0]        tail;
    logic [AW-1:0]        head_inc;

    logic                 push_en;
    logic [AW-1:0]        push_addr;
    t_note                push_data;
    logic                 drop;
    logic [BW-1:0]        beat_inc;
    logic [CW-1:0]        cnt_pushed;
    logic                 act_kept;
    logic [ELAPSED_W-1:0] el_inc;
    t_note                pop_note;

    assign urg_clamp = (i_cfg.urgency > URG_FULL) ? URG_FULL : i_cfg.urgency;
    assign urg_prod  = 16'(URG_GAIN) * 16'(urg_clamp);
    assign beat_step = FREQ_W'(urg_prod[15:8]);

    assign full     = (r_count >= DEPTH_C);
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
    assign head_inc = (r_head == HEAD_TOP) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_cur_freq = r_cur_freq;
        n_cur_len  = r_cur_len;
        n_elapsed  = r_elapsed;
        n_active   = r_active;
        n_sounding = r_sounding;
        n_metro    = r_metro;
        n_tock     = r_tock;
        n_beat     = r_beat;
        push_en    = 1'b0;
        push_addr  = tail;
        push_data  = '{len: BEAT_TONE_MS, freq: (r_tock ? TOCK_BASE : TICK_BASE) + beat_step};
        drop       = 1'b0;
        beat_inc   = r_beat + 1'b1;
        cnt_pushed = r_count;
        act_kept   = r_active;
        el_inc     = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
        pop_note   = i_head_data;

        case (i_item.cmd)
            CMD_TICK: begin
                if (r_metro) begin
                    if (beat_inc > PERIOD) begin
                        n_beat  = beat_inc - PERIOD;
                        push_en = !full;
                        n_tock  = !r_tock;
                    end else begin
                        n_beat = beat_inc;
                    end
                end
                cnt_pushed = push_en ? r_count + 1'b1 : r_count;
                if (r_active) begin
                    n_elapsed = el_inc;
                    if (el_inc > ELAPSED_W'(r_cur_len)) begin
                        act_kept   = 1'b0;
                        n_sounding = 1'b0;
                        n_cur_freq = '0;
                    end
                end
                n_active = act_kept;
                n_count  = cnt_pushed;
                if (!act_kept && (cnt_pushed != '0)) begin
                    // an empty queue can only pop the beat pushed this tick
                    pop_note   = (r_count == '0) ? push_data : i_head_data;
                    n_cur_freq = pop_note.freq;
                    n_cur_len  = pop_note.len;
                    n_active   = 1'b1;
                    n_elapsed  = '0;
                    n_sounding = (pop_note.freq != '0) && (pop_note.freq >= i_cfg.low)
                                 && (pop_note.freq <= i_cfg.high);
                    n_head     = head_inc;
                    n_count    = cnt_pushed - 1'b1;
                end
            end
            CMD_ENQUEUE: begin
                push_en   = !full;
                drop      = full;
                push_data = '{len: i_item.len, freq: i_item.freq};
                n_count   = full ? r_count : r_count + 1'b1;
            end
            CMD_CLEAR: begin
                n_count    = '0;
                n_active   = 1'b0;
                n_sounding = 1'b0;
                n_cur_freq = '0;
                n_cur_len  = '0;
                n_elapsed  = '0;
            end
            CMD_START: begin
                n_active   = 1'b0;
                n_sounding = 1'b0;
                n_cur_freq = '0;
                n_cur_len  = '0;
                n_elapsed  = '0;
                push_en    = 1'b1;
                push_addr  = r_head;
                push_data  = '{len: BEAT_TONE_MS, freq: TICK_BASE + beat_step};
                n_count    = CW'(1);
                n_beat     = '0;
                n_metro    = 1'b1;
                n_tock     = 1'b1;
            end
            CMD_STOP: begin
                n_metro = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_cur_freq <= '0;
            r_cur_len  <= '0;
            r_elapsed  <= '0;
            r_active   <= 1'b0;
            r_sounding <= 1'b0;
            r_metro    <= 1'b0;
            r_tock     <= 1'b0;
            r_beat     <= '0;
        end else if (i_adv) begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_cur_freq <= n_cur_freq;
            r_cur_len  <= n_cur_len;
            r_elapsed  <= n_elapsed;
            r_active   <= n_active;
            r_sounding <= n_sounding;
            r_metro    <= n_metro;
            r_tock     <= n_tock;
            r_beat     <= n_beat;
        end
    end

    assign o_wr_en   = i_adv && push_en;
    assign o_wr_addr = push_addr;
    assign o_wr_data = push_data;
    assign o_rd_addr = i_adv ? n_head : r_head;

    always_comb begin
        o_res.tone_on = n_active && n_sounding;
        o_res.freq    = (n_active && n_sounding) ? n_cur_freq : '0;
        o_res.busy    = (n_count != '0) || (n_active && (n_cur_freq != '0));
        o_res.fill    = FILL_W'(n_count);
        o_res.dropped = drop;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count above depth");

    a_sound_needs_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sounding |-> r_active)
        else $error("sounding without an active note");

    a_beat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat <= PERIOD)
        else $error("beat counter above period");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_item.cmd == CMD_CLEAR)) |=> ((r_count == '0) && !r_active))
        else $error("clear left notes behind");

endmodule

// ===== rtl/tone_note_queue_sequencer.sv =====
// Buzzer note sequencer with a ring queue of notes and a metronome.
// Input beats on the s_axis channel: tuser carries the command (tick, enqueue,
// clear, start metronome, stop metronome), tdata the note frequency and length
// used by enqueue. Every input beat yields exactly one status beat on m_axis:
// tone on, driven frequency, busy, queue fill and a drop flag for a refused
// enqueue.
// An accepted input beat is loaded into the input register; its state update
// is then loaded into the output register, from which the status beat leaves.
// Throughput is one beat per cycle while m_axis does not stall; the note queue
// is a one-port-write memory whose head entry is read ahead into a register so
// a tick can pop it at once.
// When m_axis stalls the output register holds its beat and s_axis tready
// drops once the input register is also occupied; nothing is lost.
// Configuration (urgency, lowest and highest sounded frequency) is written on
// the cfg channel, always ready; index 3 is ignored.
// After reset the queue is empty, no note plays, the metronome is off and the
// registers hold urgency 256, range 31 to 4978 Hz. No clearing pass is needed.
module tone_note_queue_sequencer #(
    parameter int QUEUE_DEPTH    = tnq_pkg::QUEUE_DEPTH_DEF,
    parameter int BEAT_PERIOD_MS = tnq_pkg::BEAT_PERIOD_MS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [31:0]                        i_s_axis_tdata,  // note_freq, note_length
    input  logic [tnq_pkg::CMD_W-1:0]          i_s_axis_tuser,  // cmd
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tone_on, tone_freq, busy_res, queue_fill, dropped
    output logic [23:0]                        o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tnq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tnq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tnq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_cfg    r_cfg;

    logic    adv;
    logic    wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_note   wr_data;
    t_note   head_data;
    t_result res;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.cmd  <= i_s_axis_tuser;
            r_item.freq <= i_s_axis_tdata[15:0];
            r_item.len  <= i_s_axis_tdata[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.urgency <= URG_RST;
            r_cfg.low     <= LOW_RST;
            r_cfg.high    <= HIGH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_URGENCY: r_cfg.urgency <= i_cfg_data[URG_W-1:0];
                REG_LOW:     r_cfg.low     <= i_cfg_data;
                REG_HIGH:    r_cfg.high    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tnq_core #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .BEAT_PERIOD_MS (BEAT_PERIOD_MS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .i_head_data (head_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .o_res       (res)
    );

    tnq_note_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (head_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.dropped, r_out.fill, r_out.busy, r_out.freq, r_out.tone_on};

endmodule
